// ----- hdl/uv_sphere_vertex_and_triangle_gen_macros.svh -----
// assertion macros for the uv sphere generator
`ifndef UV_SPHERE_VERTEX_AND_TRIANGLE_GEN_MACROS_SVH
`define UV_SPHERE_VERTEX_AND_TRIANGLE_GEN_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define UVS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("uvs assertion failed");
// checked at every edge, reset included
`define UVS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("uvs assertion failed");
`else
`define UVS_ASSERT(lbl, clk, rstn, prop)
`define UVS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hdl/uvs_pkg.sv -----
`default_nettype none
package uvs_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int SEG_W        = 9;
    localparam int DEN_W        = 10;
    localparam int NUM_W        = 35;
    localparam int Q_W          = 25;
    localparam int ANG_W        = 24;
    localparam int XY_W         = 33;
    localparam int Z_W          = 26;
    localparam int CORDIC_STEPS = 22;

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 33'sd652032874;

    // configuration register indexes
    localparam logic [2:0] CFG_RADIUS          = 3'd0;
    localparam logic [2:0] CFG_WIDTH_SEGMENTS  = 3'd1;
    localparam logic [2:0] CFG_HEIGHT_SEGMENTS = 3'd2;
    localparam logic [2:0] CFG_PHI_START       = 3'd3;
    localparam logic [2:0] CFG_PHI_LENGTH      = 3'd4;
    localparam logic [2:0] CFG_THETA_START     = 3'd5;
    localparam logic [2:0] CFG_THETA_LENGTH    = 3'd6;

    // arctangent of 2^-step in 2^-24 turn
    function automatic logic signed [Z_W-1:0] arc_of(input int step);
        case (step)
            0:  arc_of = 26'sd2097152;
            1:  arc_of = 26'sd1238021;
            2:  arc_of = 26'sd654136;
            3:  arc_of = 26'sd332050;
            4:  arc_of = 26'sd166669;
            5:  arc_of = 26'sd83416;
            6:  arc_of = 26'sd41718;
            7:  arc_of = 26'sd20860;
            8:  arc_of = 26'sd10430;
            9:  arc_of = 26'sd5215;
            10: arc_of = 26'sd2608;
            11: arc_of = 26'sd1304;
            12: arc_of = 26'sd652;
            13: arc_of = 26'sd326;
            14: arc_of = 26'sd163;
            15: arc_of = 26'sd81;
            16: arc_of = 26'sd41;
            17: arc_of = 26'sd20;
            18: arc_of = 26'sd10;
            19: arc_of = 26'sd5;
            20: arc_of = 26'sd3;
            21: arc_of = 26'sd1;
            default: arc_of = 26'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

// ----- hdl/uvs_div_cell.sv -----
`default_nettype none
module uvs_div_cell
    import uvs_pkg::*;
#(
    parameter int SH = 0
) (
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [NUM_W-1:0] i_rem,
    input  wire logic [Q_W-1:0]   i_q,
    output logic      [NUM_W-1:0] o_rem,
    output logic      [Q_W-1:0]   o_q
);

    logic [NUM_W:0] w_trial;

    // one restoring step: try the divisor at this bit weight
    assign w_trial = {1'b0, i_rem} - ((NUM_W+1)'(i_den) << SH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!w_trial[NUM_W]) begin
                o_rem <= w_trial[NUM_W-1:0];
                o_q   <= {i_q[Q_W-2:0], 1'b1};
            end else begin
                o_rem <= i_rem;
                o_q   <= {i_q[Q_W-2:0], 1'b0};
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/uvs_cordic_cell.sv -----
`default_nettype none
module uvs_cordic_cell
    import uvs_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic signed [XY_W-1:0] i_x,
    input  wire logic signed [XY_W-1:0] i_y,
    input  wire logic signed [Z_W-1:0]  i_z,
    output logic signed      [XY_W-1:0] o_x,
    output logic signed      [XY_W-1:0] o_y,
    output logic signed      [Z_W-1:0]  o_z
);

    localparam logic signed [Z_W-1:0] ARC = arc_of(STEP);

    logic signed [XY_W-1:0] w_xs;
    logic signed [XY_W-1:0] w_ys;

    assign w_xs = i_x >>> STEP;
    assign w_ys = i_y >>> STEP;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[Z_W-1]) begin
                o_x <= i_x - w_ys;
                o_y <= i_y + w_xs;
                o_z <= i_z - ARC;
            end else begin
                o_x <= i_x + w_ys;
                o_y <= i_y - w_xs;
                o_z <= i_z + ARC;
            end
        end
    end

endmodule
`default_nettype wire

// ----- hdl/uv_sphere_vertex_and_triangle_gen.sv -----
// channel   | valid    | stall    | payload
// ----------+----------+----------+---------------------------------------------
// request   | i_valid  | o_stall  | i_op, i_row, i_col
// result    | o_valid  | i_stall  | o_pos_*, o_norm_*, o_tex_*, o_idx_*, o_last
// config    | i_cfg_we | none     | i_cfg_idx, i_cfg_data
//
// one request enters per cycle while o_stall is low; a result leaves through 54 stages and
// the output register. the depth is set by the 25 bit-per-stage divider cells
// and the 22 cordic cells in series.
// a quad with two triangles holds the output register for two transfers.
// a stall on the result side freezes the whole chain once its final stage is
// occupied; until then empty stages still fill.
// reset restores the configuration defaults and empties the chain, no clearing pass
`default_nettype none
`include "uv_sphere_vertex_and_triangle_gen_macros.svh"
module uv_sphere_vertex_and_triangle_gen
    import uvs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_op,
    input  wire logic [8:0]         i_row,
    input  wire logic [8:0]         i_col,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [24:0]      o_pos_x,
    output logic signed [24:0]      o_pos_y,
    output logic signed [24:0]      o_pos_z,
    output logic signed [15:0]      o_norm_x,
    output logic signed [15:0]      o_norm_y,
    output logic signed [15:0]      o_norm_z,
    output logic signed [17:0]      o_tex_u,
    output logic        [16:0]      o_tex_v,
    output logic        [16:0]      o_idx_first,
    output logic        [16:0]      o_idx_second,
    output logic        [16:0]      o_idx_third,
    output logic                    o_last
);

    // stage numbering along the chain
    localparam int ST_PREP  = Q_W + 1;
    localparam int ST_POST  = ST_PREP + CORDIC_STEPS + 1;
    localparam int ST_M1    = ST_POST + 1;
    localparam int ST_M2    = ST_M1 + 1;
    localparam int ST_M3    = ST_M2 + 1;
    localparam int ST_LAST  = ST_M3 + 1;
    localparam int DEPTH    = ST_LAST + 1;

    // data that rides alongside the arithmetic
    typedef struct packed {
        logic               op;
        logic               oor;
        logic [8:0]         row;
        logic [8:0]         col;
        logic               flip_p;
        logic               flip_t;
        logic [17:0]        tex_u;
        logic [16:0]        tex_v;
    } t_side;

    // configuration
    logic [23:0] r_radius;
    logic [8:0]  r_width_seg;
    logic [8:0]  r_height_seg;
    logic [15:0] r_phi_start;
    logic [16:0] r_phi_length;
    logic [15:0] r_theta_start;
    logic [15:0] r_theta_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius       <= 24'd4096;
            r_width_seg    <= 9'd32;
            r_height_seg   <= 9'd16;
            r_phi_start    <= 16'd0;
            r_phi_length   <= 17'd65536;
            r_theta_start  <= 16'd0;
            r_theta_length <= 16'd32768;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS:          r_radius       <= i_cfg_data;
                CFG_WIDTH_SEGMENTS:  r_width_seg    <= i_cfg_data[8:0];
                CFG_HEIGHT_SEGMENTS: r_height_seg   <= i_cfg_data[8:0];
                CFG_PHI_START:       r_phi_start    <= i_cfg_data[15:0];
                CFG_PHI_LENGTH:      r_phi_length   <= i_cfg_data[16:0];
                CFG_THETA_START:     r_theta_start  <= i_cfg_data[15:0];
                CFG_THETA_LENGTH:    r_theta_length <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // segment counts clamped, pole closure
    logic [SEG_W-1:0] w_w;
    logic [SEG_W-1:0] w_h;
    logic [DEN_W-1:0] w_w1;
    logic             w_top_closed;
    logic             w_bot_closed;

    always_comb begin
        if (r_width_seg < 9'd3)                         w_w = 9'd3;
        else if (r_width_seg > SEG_W'(MAX_SEGMENTS))    w_w = SEG_W'(MAX_SEGMENTS);
        else                                            w_w = r_width_seg;
        if (r_height_seg < 9'd2)                        w_h = 9'd2;
        else if (r_height_seg > SEG_W'(MAX_SEGMENTS))   w_h = SEG_W'(MAX_SEGMENTS);
        else                                            w_h = r_height_seg;
    end

    assign w_w1         = {1'b0, w_w} + 10'd1;
    assign w_top_closed = (r_theta_start == 16'd0);
    assign w_bot_closed = ({1'b0, r_theta_start} + {1'b0, r_theta_length}) >= 17'd32768;

    // handshake and chain advance
    logic [DEPTH-1:0] r_vld;
    logic             r_ovld;
    logic             r_pend;
    logic             w_out_xfer;
    logic             w_can_load;
    logic             w_adv;
    logic             w_load;

    assign w_out_xfer = r_ovld && !i_stall;
    assign w_can_load = !r_pend && (!r_ovld || w_out_xfer);
    assign w_adv      = !r_vld[ST_LAST] || w_can_load;
    assign w_load     = r_vld[ST_LAST] && w_can_load;
    assign o_stall    = !w_adv;
    assign o_valid    = r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // stage 0: range check and dividend set-up
    logic             w_k_pos;
    logic             w_k_neg;
    logic             w_oor;
    logic [25:0]      w_prod_phi;
    logic [24:0]      w_prod_th;
    logic [10:0]      w_u_base;
    logic [10:0]      w_u_k;
    logic [NUM_W-1:0] r_num [4];
    logic [DEN_W-1:0] w_den [4];

    assign w_k_pos    = (i_row == 9'd0) && w_top_closed;
    assign w_k_neg    = !w_k_pos && (i_row == w_h) && w_bot_closed;
    assign w_oor      = i_op ? ((i_row >= w_h) || (i_col >= w_w))
                             : ((i_row > w_h) || (i_col > w_w));
    assign w_prod_phi = i_col * r_phi_length;
    assign w_prod_th  = i_row * r_theta_length;
    assign w_u_base   = {1'b0, i_col, 1'b0} + {1'b0, w_w, 1'b0};

    always_comb begin
        if (w_k_pos)      w_u_k = w_u_base + 11'd1;
        else if (w_k_neg) w_u_k = w_u_base - 11'd1;
        else              w_u_k = w_u_base;
    end

    // the texture u dividend carries an extra 2W*65536 so it stays positive
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num[0] <= {w_prod_phi, 9'd0} + {26'd0, w_w};
            r_num[1] <= {1'b0, w_prod_th, 9'd0} + {26'd0, w_h};
            r_num[2] <= {8'd0, w_u_k, 16'd0} + {26'd0, w_w};
            r_num[3] <= {9'd0, i_row, 17'd0} + {26'd0, w_h};
        end
    end

    assign w_den[0] = {w_w, 1'b0};
    assign w_den[1] = {w_h, 1'b0};
    assign w_den[2] = {w_w, 1'b0};
    assign w_den[3] = {w_h, 1'b0};

    // sideband delay line
    t_side r_side [DEPTH];
    t_side w_side_in;
    t_side w_side_prep;
    logic  w_flip_p;
    logic  w_flip_t;
    logic [17:0] w_tex_u;
    logic [16:0] w_tex_v;

    assign w_side_in = '{op: i_op, oor: w_oor, row: i_row, col: i_col,
                         flip_p: 1'b0, flip_t: 1'b0, tex_u: '0, tex_v: '0};

    // the angle set-up stage picks up the fold flags and texture results
    always_comb begin
        w_side_prep        = r_side[ST_PREP-1];
        w_side_prep.flip_p = w_flip_p;
        w_side_prep.flip_t = w_flip_t;
        w_side_prep.tex_u  = w_tex_u;
        w_side_prep.tex_v  = w_tex_v;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= w_side_in;
            for (int s = 1; s < DEPTH; s++) begin
                if (s == ST_PREP) begin
                    r_side[s] <= w_side_prep;
                end else begin
                    r_side[s] <= r_side[s-1];
                end
            end
        end
    end

    // divider chains: phi, theta, tex u, tex v
    logic [NUM_W-1:0] w_rem [4][Q_W+1];
    logic [Q_W-1:0]   w_q   [4][Q_W+1];

    for (genvar d = 0; d < 4; d++) begin : g_div
        assign w_rem[d][0] = r_num[d];
        assign w_q[d][0]   = '0;
        for (genvar j = 0; j < Q_W; j++) begin : g_cell
            uvs_div_cell #(
                .SH (Q_W - 1 - j)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_den (w_den[d]),
                .i_rem (w_rem[d][j]),
                .i_q   (w_q[d][j]),
                .o_rem (w_rem[d][j+1]),
                .o_q   (w_q[d][j+1])
            );
        end
    end

    // angle set-up: add start, fold into a quarter turn either side of zero
    logic [ANG_W-1:0]     w_ang [2];
    logic signed [Z_W-1:0] w_zf [2];
    logic                  w_fl [2];
    logic signed [Z_W-1:0] r_z  [2];

    assign w_ang[0] = {r_phi_start, 8'd0} + w_q[0][Q_W][ANG_W-1:0];
    assign w_ang[1] = {r_theta_start, 8'd0} + w_q[1][Q_W][ANG_W-1:0];

    always_comb begin
        logic signed [Z_W-1:0] v;
        for (int a = 0; a < 2; a++) begin
            v = Z_W'($signed(w_ang[a]));
            if (v > 26'sd4194304) begin
                w_zf[a] = v - 26'sd8388608;
                w_fl[a] = 1'b1;
            end else if (v < -26'sd4194304) begin
                w_zf[a] = v + 26'sd8388608;
                w_fl[a] = 1'b1;
            end else begin
                w_zf[a] = v;
                w_fl[a] = 1'b0;
            end
        end
    end

    assign w_flip_p = w_fl[0];
    assign w_flip_t = w_fl[1];
    assign w_tex_u  = 18'(w_q[2][Q_W] - 25'd65536);
    assign w_tex_v  = 17'd65536 - w_q[3][Q_W][16:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_z[0] <= w_zf[0];
            r_z[1] <= w_zf[1];
        end
    end

    // cordic chains, phi then theta
    logic signed [XY_W-1:0] w_cx [2][CORDIC_STEPS+1];
    logic signed [XY_W-1:0] w_cy [2][CORDIC_STEPS+1];
    logic signed [Z_W-1:0]  w_cz [2][CORDIC_STEPS+1];

    for (genvar a = 0; a < 2; a++) begin : g_cordic
        assign w_cx[a][0] = CORDIC_X0;
        assign w_cy[a][0] = '0;
        assign w_cz[a][0] = r_z[a];
        for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
            uvs_cordic_cell #(
                .STEP (i)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_adv),
                .i_x   (w_cx[a][i]),
                .i_y   (w_cy[a][i]),
                .i_z   (w_cz[a][i]),
                .o_x   (w_cx[a][i+1]),
                .o_y   (w_cy[a][i+1]),
                .o_z   (w_cz[a][i+1])
            );
        end
    end

    // clamp to +-2^30 and undo the half-turn fold
    function automatic logic signed [31:0] sat_flip(input logic signed [XY_W-1:0] v,
                                                    input logic f);
        logic signed [31:0] s;
        if (v > 33'sd1073741824)       s = 32'sd1073741824;
        else if (v < -33'sd1073741824) s = -32'sd1073741824;
        else                           s = v[31:0];
        return f ? -s : s;
    endfunction

    logic signed [31:0] r_cp;
    logic signed [31:0] r_sp;
    logic signed [31:0] r_ct;
    logic signed [31:0] r_st;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cp <= sat_flip(w_cx[0][CORDIC_STEPS], r_side[ST_POST-1].flip_p);
            r_sp <= sat_flip(w_cy[0][CORDIC_STEPS], r_side[ST_POST-1].flip_p);
            r_ct <= sat_flip(w_cx[1][CORDIC_STEPS], r_side[ST_POST-1].flip_t);
            r_st <= sat_flip(w_cy[1][CORDIC_STEPS], r_side[ST_POST-1].flip_t);
        end
    end

    // direction products
    logic signed [63:0] r_px;
    logic signed [63:0] r_pz;
    logic signed [31:0] r_ct1;
    logic signed [63:0] w_rx;
    logic signed [63:0] w_rz;
    logic signed [31:0] r_dx;
    logic signed [31:0] r_dy;
    logic signed [31:0] r_dz;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_px  <= r_cp * r_st;
            r_pz  <= r_sp * r_st;
            r_ct1 <= r_ct;
        end
    end

    assign w_rx = (r_px + 64'sd536870912) >>> 30;
    assign w_rz = (r_pz + 64'sd536870912) >>> 30;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx <= -w_rx[31:0];
            r_dy <= r_ct1;
            r_dz <= w_rz[31:0];
        end
    end

    // radius scaling, normal rounding, base vertex index
    function automatic logic signed [15:0] norm_of(input logic signed [31:0] d);
        logic signed [32:0] r;
        r = (33'(d) + 33'sd16384) >>> 15;
        if (r > 33'sd32767)       return 16'sd32767;
        else if (r < -33'sd32767) return -16'sd32767;
        else                      return r[15:0];
    endfunction

    function automatic logic signed [24:0] pos_of(input logic signed [56:0] p);
        logic signed [57:0] r;
        r = (58'(p) + 58'sd536870912) >>> 30;
        if (r > 58'sd16777215)       return 25'sd16777215;
        else if (r < -58'sd16777215) return -25'sd16777215;
        else                         return r[24:0];
    endfunction

    logic signed [24:0] w_rad;
    logic signed [56:0] r_prx;
    logic signed [56:0] r_pry;
    logic signed [56:0] r_prz;
    logic signed [15:0] r_nx3;
    logic signed [15:0] r_ny3;
    logic signed [15:0] r_nz3;
    logic [18:0]        w_bprod;
    logic [16:0]        r_b3;

    assign w_rad   = $signed({1'b0, r_radius});
    assign w_bprod = r_side[ST_M3-1].row * w_w1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_prx <= w_rad * r_dx;
            r_pry <= w_rad * r_dy;
            r_prz <= w_rad * r_dz;
            r_nx3 <= norm_of(r_dx);
            r_ny3 <= norm_of(r_dy);
            r_nz3 <= norm_of(r_dz);
            r_b3  <= 17'(w_bprod + 19'(r_side[ST_M3-1].col));
        end
    end

    // last stage
    logic signed [24:0] r_pos_x;
    logic signed [24:0] r_pos_y;
    logic signed [24:0] r_pos_z;
    logic signed [15:0] r_nx;
    logic signed [15:0] r_ny;
    logic signed [15:0] r_nz;
    logic [16:0]        r_b;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pos_x <= pos_of(r_prx);
            r_pos_y <= pos_of(r_pry);
            r_pos_z <= pos_of(r_prz);
            r_nx    <= r_nx3;
            r_ny    <= r_ny3;
            r_nz    <= r_nz3;
            r_b     <= r_b3;
        end
    end

    // result forming: quads give (a,b,d) then (b,c,d), each skipped at a closed pole
    t_side       w_ls;
    logic        w_tri1;
    logic        w_tri2;
    logic [16:0] w_ia;
    logic [16:0] w_ic;
    logic [16:0] w_id;

    assign w_ls   = r_side[ST_LAST];
    assign w_tri1 = !((w_ls.row == 9'd0) && w_top_closed);
    assign w_tri2 = !((w_ls.row == (w_h - 9'd1)) && w_bot_closed);
    assign w_ia   = r_b + 17'd1;
    assign w_ic   = r_b + {8'd0, w_w} + 17'd1;
    assign w_id   = w_ic + 17'd1;

    // first result of the request in the final stage, all-zero when out of range
    logic signed [24:0] n_pos_x;
    logic signed [24:0] n_pos_y;
    logic signed [24:0] n_pos_z;
    logic signed [15:0] n_norm_x;
    logic signed [15:0] n_norm_y;
    logic signed [15:0] n_norm_z;
    logic signed [17:0] n_tex_u;
    logic        [16:0] n_tex_v;
    logic        [16:0] n_idx_first;
    logic        [16:0] n_idx_second;
    logic        [16:0] n_idx_third;
    logic               n_last;
    logic               n_pend;

    always_comb begin
        n_pos_x      = '0;
        n_pos_y      = '0;
        n_pos_z      = '0;
        n_norm_x     = '0;
        n_norm_y     = '0;
        n_norm_z     = '0;
        n_tex_u      = '0;
        n_tex_v      = '0;
        n_idx_first  = '0;
        n_idx_second = '0;
        n_idx_third  = '0;
        n_last       = 1'b1;
        n_pend       = 1'b0;
        if (!w_ls.oor) begin
            if (!w_ls.op) begin
                n_pos_x  = r_pos_x;
                n_pos_y  = r_pos_y;
                n_pos_z  = r_pos_z;
                n_norm_x = r_nx;
                n_norm_y = r_ny;
                n_norm_z = r_nz;
                n_tex_u  = w_ls.tex_u;
                n_tex_v  = w_ls.tex_v;
            end else if (w_tri1) begin
                n_idx_first  = w_ia;
                n_idx_second = r_b;
                n_idx_third  = w_id;
                n_last       = !w_tri2;
                n_pend       = w_tri2;
            end else begin
                n_idx_first  = r_b;
                n_idx_second = w_ic;
                n_idx_third  = w_id;
            end
        end
    end

    // output register with one pending triangle behind it
    logic [16:0] r_pend_b;
    logic [16:0] r_pend_c;
    logic [16:0] r_pend_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (w_out_xfer && r_pend) begin
                r_ovld       <= 1'b1;
                r_pend       <= 1'b0;
                o_idx_first  <= r_pend_b;
                o_idx_second <= r_pend_c;
                o_idx_third  <= r_pend_d;
                o_last       <= 1'b1;
            end else if (w_load) begin
                r_ovld       <= 1'b1;
                o_pos_x      <= n_pos_x;
                o_pos_y      <= n_pos_y;
                o_pos_z      <= n_pos_z;
                o_norm_x     <= n_norm_x;
                o_norm_y     <= n_norm_y;
                o_norm_z     <= n_norm_z;
                o_tex_u      <= n_tex_u;
                o_tex_v      <= n_tex_v;
                o_idx_first  <= n_idx_first;
                o_idx_second <= n_idx_second;
                o_idx_third  <= n_idx_third;
                o_last       <= n_last;
                r_pend_b     <= r_b;
                r_pend_c     <= w_ic;
                r_pend_d     <= w_id;
                r_pend       <= n_pend;
            end else if (w_out_xfer) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // a second triangle waits only behind a shown first one
    `UVS_ASSERT(a_pend_needs_out, i_clk, i_rst_n, r_pend |-> (r_ovld && !o_last))
    // a transfer without last is always followed by the closing triangle
    `UVS_ASSERT(a_first_then_second, i_clk, i_rst_n, (w_out_xfer && !o_last) |=> (o_valid && o_last))
    // a frozen chain keeps its final stage
    `UVS_ASSERT(a_hold_when_frozen, i_clk, i_rst_n, (!w_adv && r_vld[ST_LAST]) |=> r_vld[ST_LAST])
    // nothing is shown or pending straight after reset
    `UVS_ASSERT_ALWAYS(a_reset_empty, i_clk, !$past(i_rst_n) |-> (!r_ovld && !r_pend))

endmodule
`default_nettype wire

// ----- sim/uvs_mesh_checker.sv -----
`timescale 1ns / 100ps
module uvs_mesh_checker
    import uvs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_req_valid,
    input  wire logic               i_req_stall,
    input  wire logic               i_op,
    input  wire logic [8:0]         i_row,
    input  wire logic [8:0]         i_col,
    input  wire logic               i_res_valid,
    input  wire logic               i_res_stall,
    input  wire logic signed [24:0] i_pos_x,
    input  wire logic signed [24:0] i_pos_y,
    input  wire logic signed [24:0] i_pos_z,
    input  wire logic signed [15:0] i_norm_x,
    input  wire logic signed [15:0] i_norm_y,
    input  wire logic signed [15:0] i_norm_z,
    input  wire logic signed [17:0] i_tex_u,
    input  wire logic        [16:0] i_tex_v,
    input  wire logic        [16:0] i_idx_first,
    input  wire logic        [16:0] i_idx_second,
    input  wire logic        [16:0] i_idx_third,
    input  wire logic               i_last,
    output int                      o_fail_count,
    output int                      o_outstanding
);

    typedef struct packed {
        logic signed [24:0] pos_x;
        logic signed [24:0] pos_y;
        logic signed [24:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic signed [17:0] tex_u;
        logic        [16:0] tex_v;
        logic        [16:0] idx_first;
        logic        [16:0] idx_second;
        logic        [16:0] idx_third;
        logic               last;
    } mesh_result_t;

    localparam longint ARC_TURN [22] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1
    };

    mesh_result_t expected_mesh[$];

    logic [23:0] radius_q;
    logic [8:0]  width_segs, height_segs;
    logic [15:0] phi_start_q, theta_start_q, theta_length_q;
    logic [16:0] phi_length_q;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic longint div_floor(longint n, longint d);
        return n >= 0 ? n / d : -((-n + d - 1) / d);
    endfunction

    function automatic longint seg_clamp(longint v, longint lo);
        longint n;
        n = v < lo ? lo : v;
        return n > MAX_SEGMENTS ? MAX_SEGMENTS : n;
    endfunction

    // rotation-mode cordic on a 2^-24 turn angle, results in Q2.30
    function automatic void turn_sin_cos(input longint ang, output longint s,
                                         output longint c);
        longint z, x, y, xs, ys;
        bit flip;
        z = ang & 64'hFF_FFFF;
        x = 652032874;
        y = 0;
        flip = 0;
        if (z >= 64'sh80_0000) z -= 64'h100_0000;
        if (z > 64'sh40_0000) begin
            z -= 64'h80_0000;
            flip = 1;
        end else if (z < -64'sh40_0000) begin
            z += 64'h80_0000;
            flip = 1;
        end
        for (int i = 0; i < 22; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ARC_TURN[i];
            end else begin
                x += ys; y -= xs; z += ARC_TURN[i];
            end
        end
        x = clip(x, longint'(1) << 30);
        y = clip(y, longint'(1) << 30);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    task automatic predict_mesh(input logic op, input longint row, input longint col);
        mesh_result_t r;
        longint w, h, phi, th, sp, cp, st, ct, kk, b;
        longint dir[3];
        bit top_closed, bot_closed;
        w = seg_clamp(width_segs, 3);
        h = seg_clamp(height_segs, 2);
        top_closed = theta_start_q == 0;
        bot_closed = longint'(theta_start_q) + theta_length_q >= 32768;
        r = '0;
        if (op == 1'b0) begin
            if (row <= h && col <= w) begin
                phi = (longint'(phi_start_q) << 8) + (2 * col * phi_length_q * 256 + w) / (2 * w);
                th = (longint'(theta_start_q) << 8)
                     + (2 * row * theta_length_q * 256 + h) / (2 * h);
                turn_sin_cos(phi, sp, cp);
                turn_sin_cos(th, st, ct);
                dir[0] = -round_shift(cp * st, 30);
                dir[1] = ct;
                dir[2] = round_shift(sp * st, 30);
                r.pos_x  = clip(round_shift(longint'(radius_q) * dir[0], 30), 16777215);
                r.pos_y  = clip(round_shift(longint'(radius_q) * dir[1], 30), 16777215);
                r.pos_z  = clip(round_shift(longint'(radius_q) * dir[2], 30), 16777215);
                r.norm_x = clip(round_shift(dir[0], 15), 32767);
                r.norm_y = clip(round_shift(dir[1], 15), 32767);
                r.norm_z = clip(round_shift(dir[2], 15), 32767);
                // half-cell shift of u on closed pole rows
                kk = 0;
                if (row == 0 && top_closed) kk = 1;
                else if (row == h && bot_closed) kk = -1;
                r.tex_u = div_floor((2 * col + kk) * 65536 + w, 2 * w);
                r.tex_v = 65536 - (row * 131072 + h) / (2 * h);
            end
            r.last = 1'b1;
            expected_mesh = {expected_mesh, r};
        end else if (row >= h || col >= w) begin
            r.last = 1'b1;
            expected_mesh = {expected_mesh, r};
        end else begin
            b = row * (w + 1) + col;
            if (row != 0 || !top_closed) begin
                r.idx_first  = b + 1;
                r.idx_second = b;
                r.idx_third  = b + w + 2;
                r.last       = !(row != h - 1 || !bot_closed);
                expected_mesh = {expected_mesh, r};
                r = '0;
            end
            if (row != h - 1 || !bot_closed) begin
                r.idx_first  = b;
                r.idx_second = b + w + 1;
                r.idx_third  = b + w + 2;
                r.last       = 1'b1;
                expected_mesh = {expected_mesh, r};
            end
        end
    endtask

    task automatic check_field(input string nm, input logic [24:0] want,
                               input logic [24:0] got);
        if (want !== got) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
        end
    endtask

    initial begin
        o_fail_count = 0;
    end

    assign o_outstanding = expected_mesh.size();

    always @(posedge i_clk) begin
        mesh_result_t want;
        // mirror of the register file
        if (!i_rst_n) begin
            radius_q       <= 24'd4096;
            width_segs     <= 9'd32;
            height_segs    <= 9'd16;
            phi_start_q    <= '0;
            phi_length_q   <= 17'd65536;
            theta_start_q  <= '0;
            theta_length_q <= 16'd32768;
            expected_mesh.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS:          radius_q       <= i_cfg_data;
                    CFG_WIDTH_SEGMENTS:  width_segs     <= i_cfg_data[8:0];
                    CFG_HEIGHT_SEGMENTS: height_segs    <= i_cfg_data[8:0];
                    CFG_PHI_START:       phi_start_q    <= i_cfg_data[15:0];
                    CFG_PHI_LENGTH:      phi_length_q   <= i_cfg_data[16:0];
                    CFG_THETA_START:     theta_start_q  <= i_cfg_data[15:0];
                    CFG_THETA_LENGTH:    theta_length_q <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // results first, so a request predicted this edge never meets its own result
            if (i_res_valid && !i_res_stall) begin
                if (expected_mesh.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result transfer with nothing expected", $time);
                end else begin
                    want = expected_mesh.pop_front();
                    check_field("pos_x", 25'(want.pos_x), 25'(i_pos_x));
                    check_field("pos_y", 25'(want.pos_y), 25'(i_pos_y));
                    check_field("pos_z", 25'(want.pos_z), 25'(i_pos_z));
                    check_field("norm_x", 25'(want.norm_x), 25'(i_norm_x));
                    check_field("norm_y", 25'(want.norm_y), 25'(i_norm_y));
                    check_field("norm_z", 25'(want.norm_z), 25'(i_norm_z));
                    check_field("tex_u", 25'(want.tex_u), 25'(i_tex_u));
                    check_field("tex_v", 25'(want.tex_v), 25'(i_tex_v));
                    check_field("idx_first", 25'(want.idx_first), 25'(i_idx_first));
                    check_field("idx_second", 25'(want.idx_second), 25'(i_idx_second));
                    check_field("idx_third", 25'(want.idx_third), 25'(i_idx_third));
                    check_field("last", 25'(want.last), 25'(i_last));
                end
            end
            if (i_req_valid && !i_req_stall)
                predict_mesh(i_op, longint'(i_row), longint'(i_col));
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
    import uvs_pkg::*;

    // run limit in cycles, far above the slowest correct run
    localparam int CYCLE_LIMIT = 600000;
    // pipeline depth plus margin
    localparam int DRAIN_CYCLES = 80;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic i_op = 1'b0;
    logic [8:0] i_row = '0;
    logic [8:0] i_col = '0;
    logic i_stall = 1'b0;

    wire logic o_stall, o_valid, o_last;
    wire logic signed [24:0] o_pos_x, o_pos_y, o_pos_z;
    wire logic signed [15:0] o_norm_x, o_norm_y, o_norm_z;
    wire logic signed [17:0] o_tex_u;
    wire logic [16:0] o_tex_v, o_idx_first, o_idx_second, o_idx_third;

    int fail_count, outstanding;
    int cycle_count = 0;
    int vertex_reqs = 0, quad_reqs = 0, phases_run = 0;

    // stimulus-side copy of the segment counts, used to aim requests at the grid
    int grid_w = 32, grid_h = 16;

    // sender and receiver behaviour
    bit calm_mode = 1'b0;
    bit long_hold_req = 1'b0;
    int long_hold_left = 0;
    int rx_wait = 0;

    always #1 i_clk = ~i_clk;

    uv_sphere_vertex_and_triangle_gen dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_row(i_row), .i_col(i_col),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pos_x(o_pos_x), .o_pos_y(o_pos_y), .o_pos_z(o_pos_z),
        .o_norm_x(o_norm_x), .o_norm_y(o_norm_y), .o_norm_z(o_norm_z),
        .o_tex_u(o_tex_u), .o_tex_v(o_tex_v),
        .o_idx_first(o_idx_first), .o_idx_second(o_idx_second), .o_idx_third(o_idx_third),
        .o_last(o_last)
    );

    uvs_mesh_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_req_valid(i_valid), .i_req_stall(o_stall),
        .i_op(i_op), .i_row(i_row), .i_col(i_col),
        .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_pos_x(o_pos_x), .i_pos_y(o_pos_y), .i_pos_z(o_pos_z),
        .i_norm_x(o_norm_x), .i_norm_y(o_norm_y), .i_norm_z(o_norm_z),
        .i_tex_u(o_tex_u), .i_tex_v(o_tex_v),
        .i_idx_first(o_idx_first), .i_idx_second(o_idx_second),
        .i_idx_third(o_idx_third), .i_last(o_last),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("tb_top: errors");
            $finish;
        end
    end

    // result side: random stall per result slot, one long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (long_hold_req && long_hold_left == 0) begin
            long_hold_req = 1'b0;
            long_hold_left = 300;
            i_stall <= 1'b1;
        end else if (long_hold_left > 0) begin
            long_hold_left--;
            i_stall <= long_hold_left != 0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            rx_wait = calm_mode ? 0 : $urandom_range(0, 5);
        end
    end

    // offer one request, return once its transfer has happened (at the next falling edge)
    task automatic send_request(input logic op, input int row, input int col);
        int gap;
        gap = calm_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_row   <= row[8:0];
        i_col   <= col[8:0];
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if (op) quad_reqs++;
        else vertex_reqs++;
    endtask

    // register writes happen only with the chain empty
    task automatic load_sphere(input int radius, input int wseg, input int hseg,
                               input int phi0, input int phil, input int th0,
                               input int thl);
        int vals[7];
        vals = '{radius, wseg, hseg, phi0, phil, th0, thl};
        i_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        for (int i = 0; i < 7; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(i);
            i_cfg_data <= 24'(vals[i]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        grid_w = wseg < 3 ? 3 : (wseg > MAX_SEGMENTS ? MAX_SEGMENTS : wseg);
        grid_h = hseg < 2 ? 2 : (hseg > MAX_SEGMENTS ? MAX_SEGMENTS : hseg);
        phases_run++;
    endtask

    // mostly on-grid requests, some anywhere from 0 to 256 in row and column
    task automatic random_burst(input int count);
        int row, col;
        logic op;
        for (int n = 0; n < count; n++) begin
            // switch sender and receiver between jittery and back-to-back stretches
            if (n % 64 == 0) calm_mode = ($urandom_range(0, 3) == 0);
            op = $urandom_range(0, 1);
            if ($urandom_range(0, 9) == 0) begin
                row = $urandom_range(0, 256);
                col = $urandom_range(0, 256);
            end else begin
                row = $urandom_range(0, op ? grid_h - 1 : grid_h);
                col = $urandom_range(0, op ? grid_w - 1 : grid_w);
            end
            send_request(op, row, col);
        end
        calm_mode = 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: poles, seam, corners, out of range, both triangle cases
        send_request(1'b0, 0, 0);
        send_request(1'b0, 0, 32);
        send_request(1'b0, 16, 0);
        send_request(1'b0, 16, 32);
        send_request(1'b0, 8, 16);
        send_request(1'b0, 4, 7);
        send_request(1'b0, 17, 0);
        send_request(1'b0, 0, 33);
        send_request(1'b0, 256, 256);
        send_request(1'b1, 0, 0);
        send_request(1'b1, 0, 31);
        send_request(1'b1, 15, 0);
        send_request(1'b1, 15, 31);
        send_request(1'b1, 7, 9);
        send_request(1'b1, 16, 0);
        send_request(1'b1, 0, 32);
        send_request(1'b1, 256, 256);

        // open sphere band, zero radius: no pole skipping, normals without positions
        load_sphere(0, 5, 4, 16384, 32768, 4096, 8192);
        send_request(1'b0, 0, 0);
        send_request(1'b0, 4, 5);
        send_request(1'b1, 0, 0);
        send_request(1'b1, 3, 4);
        random_burst(120);

        // lower extremes, clamped segment counts
        load_sphere(0, 0, 0, 0, 0, 0, 0);
        random_burst(150);

        // upper extremes, full-size grid, overshooting theta end
        load_sphere(16777215, 256, 256, 65535, 65536, 32768, 32768);
        send_request(1'b0, 256, 256);
        send_request(1'b1, 255, 255);
        random_burst(200);

        // raw segment register above the cap
        load_sphere(16777215, 511, 300, 0, 65536, 0, 32768);
        random_burst(150);

        // back-pressure: hold the result side while requests keep coming
        load_sphere(4096, 8, 6, 0, 65536, 0, 32768);
        long_hold_req = 1'b1;
        calm_mode = 1'b1;
        for (int n = 0; n < 120; n++)
            send_request(1'(n % 2), n % 7, n % 9);
        calm_mode = 1'b0;

        for (int p = 0; p < 6; p++) begin
            load_sphere($urandom_range(0, 16777215), $urandom_range(0, 40),
                        $urandom_range(0, 40), $urandom_range(0, 65535),
                        $urandom_range(0, 65536),
                        $urandom_range(0, 1) ? 0 : $urandom_range(0, 32768),
                        $urandom_range(0, 32768));
            random_burst(160);
        end

        i_valid <= 1'b0;
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d vertex and %0d quad requests over %0d sphere settings",
                 vertex_reqs, quad_reqs, phases_run + 1);
        $display("including extreme settings and a long result-side hold-off");
        if (fail_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

// ----- uv_sphere_vertex_and_triangle_gen.f -----
+incdir+hdl
hdl/uvs_pkg.sv
hdl/uvs_div_cell.sv
hdl/uvs_cordic_cell.sv
hdl/uv_sphere_vertex_and_triangle_gen.sv
sim/uvs_mesh_checker.sv
sim/tb_top.sv
